>>> rtl/core/mrd_pkg.sv
`default_nettype none
package mrd_pkg;

  localparam int TimeBitsDef  = 47;
  localparam int CountBitsDef = 16;

  localparam int ThrW   = 16;
  localparam int IntvW  = 32;
  localparam int LevelW = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int OutcomeW = 2;
  localparam int OutDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgLowThr   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHighThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHoldoff  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLevel    = 3'd4;

  localparam logic [OutcomeW-1:0] OutcomeSkip   = 2'd0;
  localparam logic [OutcomeW-1:0] OutcomeNone   = 2'd1;
  localparam logic [OutcomeW-1:0] OutcomeReport = 2'd2;

  localparam logic [LevelW-1:0] LevelReset = 8'd2;
  localparam logic [LevelW-1:0] QuietStart = 8'd2;
  localparam logic [LevelW-1:0] CounterMax = 8'd255;

  typedef struct packed {
    logic [ThrW-1:0]   low_thr;
    logic [ThrW-1:0]   high_thr;
    logic [IntvW-1:0]  interval;
    logic [IntvW-1:0]  holdoff;
    logic [LevelW-1:0] level;
  } cfg_t;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [LevelW-1:0]   level;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/mrd_cfg_regs.sv
`default_nettype none
module mrd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mrd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output mrd_pkg::cfg_t                      cfg_o
);

  mrd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr  <= '0;
      cfg_q.high_thr <= '0;
      cfg_q.interval <= '0;
      cfg_q.holdoff  <= '0;
      cfg_q.level    <= mrd_pkg::LevelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mrd_pkg::CfgLowThr:   cfg_q.low_thr  <= cfg_wdata_i[mrd_pkg::ThrW-1:0];
        mrd_pkg::CfgHighThr:  cfg_q.high_thr <= cfg_wdata_i[mrd_pkg::ThrW-1:0];
        mrd_pkg::CfgInterval: cfg_q.interval <= cfg_wdata_i[mrd_pkg::IntvW-1:0];
        mrd_pkg::CfgHoldoff:  cfg_q.holdoff  <= cfg_wdata_i[mrd_pkg::IntvW-1:0];
        mrd_pkg::CfgLevel:    cfg_q.level    <= cfg_wdata_i[mrd_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/mrd_in_reg.sv
`default_nettype none
module mrd_in_reg #(
  parameter int TIME_BITS  = mrd_pkg::TimeBitsDef,
  parameter int COUNT_BITS = mrd_pkg::CountBitsDef,
  localparam int InW = ((TIME_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic                   adv_i,
  input  wire logic [InW-1:0]         tdata_i,
  output logic                        valid_o,
  output logic [TIME_BITS-1:0]        now_o,
  output logic [COUNT_BITS-1:0]       count_o
);

  logic                  valid_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [COUNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      now_q   <= tdata_i[TIME_BITS-1:0];
      count_q <= tdata_i[TIME_BITS +: COUNT_BITS];
    end
  end

  assign valid_o = valid_q;
  assign now_o   = now_q;
  assign count_o = count_q;

endmodule
`default_nettype wire

>>> rtl/core/mrd_decide.sv
`default_nettype none
module mrd_decide #(
  parameter int TIME_BITS  = mrd_pkg::TimeBitsDef,
  parameter int COUNT_BITS = mrd_pkg::CountBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire logic [TIME_BITS-1:0]   now_i,
  input  wire logic [COUNT_BITS-1:0]  count_i,
  input  mrd_pkg::cfg_t               cfg_i,
  output mrd_pkg::res_t               res_o
);

  localparam int SumW = ((TIME_BITS > mrd_pkg::IntvW) ? TIME_BITS : mrd_pkg::IntvW) + 1;
  localparam int CmpW = (COUNT_BITS > mrd_pkg::ThrW) ? COUNT_BITS : mrd_pkg::ThrW;

  logic [TIME_BITS-1:0]      last_frame_q, last_report_q;
  logic                      frame_set_q, report_set_q, reported_q;
  logic [mrd_pkg::LevelW-1:0] trk_q, trk_d;

  logic [SumW-1:0] now_ext, frame_ref, frame_lim, report_ref, report_lim;
  logic [CmpW-1:0] cnt_ext, low_ext, high_ext;
  logic            skip, report;
  logic [mrd_pkg::LevelW-1:0] cnt0;

  always_comb begin
    now_ext   = SumW'(now_i);
    frame_ref = frame_set_q ? SumW'(last_frame_q) : SumW'(cfg_i.interval);
    frame_lim = frame_ref + SumW'(cfg_i.interval);
    skip      = now_ext < frame_lim;

    cnt_ext  = CmpW'(count_i);
    low_ext  = CmpW'(cfg_i.low_thr);
    high_ext = CmpW'(cfg_i.high_thr);

    // counter clears on the frame after a report
    cnt0 = (trk_q >= cfg_i.level && reported_q) ? '0 : trk_q;

    priority if (cnt0 == '0 && cnt_ext > high_ext) begin
      trk_d = mrd_pkg::LevelW'(1);
    end else if (cnt0 == mrd_pkg::LevelW'(1) && cnt_ext < low_ext) begin
      trk_d = mrd_pkg::QuietStart;
    end else if (cnt0 >= mrd_pkg::QuietStart) begin
      if (cnt_ext < low_ext) begin
        trk_d = (cnt0 == mrd_pkg::CounterMax) ? cnt0 : cnt0 + mrd_pkg::LevelW'(1);
      end else begin
        trk_d = mrd_pkg::LevelW'(1);
      end
    end else begin
      trk_d = cnt0;
    end

    report_ref = report_set_q ? SumW'(last_report_q) : SumW'(cfg_i.holdoff);
    report_lim = report_ref + SumW'(cfg_i.holdoff);
    report     = trk_d >= cfg_i.level && now_ext >= report_lim;

    if (skip) begin
      res_o.outcome = mrd_pkg::OutcomeSkip;
      res_o.level   = trk_q;
    end else begin
      res_o.outcome = report ? mrd_pkg::OutcomeReport : mrd_pkg::OutcomeNone;
      res_o.level   = trk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_frame_q  <= '0;
      last_report_q <= '0;
      frame_set_q   <= 1'b0;
      report_set_q  <= 1'b0;
      reported_q    <= 1'b0;
      trk_q         <= '0;
    end else if (adv_i && !skip) begin
      last_frame_q <= now_i;
      frame_set_q  <= 1'b1;
      trk_q        <= trk_d;
      reported_q   <= report;
      if (report) begin
        last_report_q <= now_i;
        report_set_q  <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mrd_out_reg.sv
`default_nettype none
module mrd_out_reg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic                          tready_i,
  input  mrd_pkg::res_t                      res_i,
  output logic                               tvalid_o,
  output logic [mrd_pkg::OutDataW-1:0]       tdata_o
);

  logic          valid_q;
  mrd_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = mrd_pkg::OutDataW'({res_q.level, res_q.outcome});

endmodule
`default_nettype wire

>>> rtl/core/motion_report_decider_core.sv
`default_nettype none
// An accepted item is held in the input register, then its result in the result register.
// One item per cycle unless the output stalls; the decision is a single pass between them.
// For a frame that is not skipped, the tracking state updates at the same edge the result is registered.
// Reset (rst_ni, async, active low): empty pipeline, state cleared,
// config registers at reset values (report level 2, others 0).
module motion_report_decider_core #(
  parameter int TIME_BITS  = mrd_pkg::TimeBitsDef,
  parameter int COUNT_BITS = mrd_pkg::CountBitsDef,
  localparam int InW = ((TIME_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mrd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_time, change_count, zero pad
  input  wire logic [InW-1:0]                s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // outcome[1:0], tracking_level[9:2], zero pad
  output logic [mrd_pkg::OutDataW-1:0]       m_axis_tdata
);

  mrd_pkg::cfg_t         cfg;
  mrd_pkg::res_t         res;
  logic                  in_valid, adv, load;
  logic [TIME_BITS-1:0]  now;
  logic [COUNT_BITS-1:0] count;

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || !m_axis_tvalid || m_axis_tready;
  assign load          = s_axis_tvalid && s_axis_tready;

  mrd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mrd_in_reg #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .adv_i   (adv),
    .tdata_i (s_axis_tdata),
    .valid_o (in_valid),
    .now_o   (now),
    .count_o (count)
  );

  mrd_decide #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .now_i   (now),
    .count_i (count),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  mrd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .tready_i (m_axis_tready),
    .res_i    (res),
    .tvalid_o (m_axis_tvalid),
    .tdata_o  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in pipeline");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == mrd_pkg::OutcomeSkip ||
                       m_axis_tdata[1:0] == mrd_pkg::OutcomeNone ||
                       m_axis_tdata[1:0] == mrd_pkg::OutcomeReport))
    else $error("bad outcome code");

  a_skip_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.outcome == mrd_pkg::OutcomeSkip) |=> $stable(u_decide.trk_q))
    else $error("skipped frame changed tracking level");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("result lost after advance");
`endif

endmodule
`default_nettype wire

>>> bench/motion_report_decider_core_tb.sv
module motion_report_decider_core_tb;
  import mrd_pkg::*;

  localparam int TimeW = TimeBitsDef;
  localparam int CountW = CountBitsDef;
  localparam logic [63:0] TimeMax = 64'h7FFF_FFFF_FFFF;
  localparam int StallLimit = 2000;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        wdata;
    logic [TimeW-1:0]   now;
    logic [CountW-1:0]  cnt;
    logic               typed;
    logic [OutcomeW-1:0] oc;
    logic [LevelW-1:0]  lv;
  } plan_row_t;

  // register writes and frames; typed rows carry the decision read straight off the rules
  localparam plan_row_t Plan [33] = '{
    '{1'b1, CfgInterval, 32'd10, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgHoldoff, 32'd3, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd15, 16'd0, 1'b1, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd20, 16'd0, 1'b1, OutcomeNone, 8'd0},
    '{1'b1, CfgInterval, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd20, 16'd65535, 1'b1, OutcomeNone, 8'd1},
    '{1'b0, CfgLowThr, 32'd0, 47'd21, 16'd5, 1'b1, OutcomeNone, 8'd1},
    '{1'b1, CfgLowThr, 32'd65535, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgHighThr, 32'd65535, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd22, 16'd0, 1'b1, OutcomeReport, 8'd2},
    '{1'b0, CfgLowThr, 32'd0, 47'd23, 16'd65535, 1'b1, OutcomeNone, 8'd0},
    '{1'b1, CfgHighThr, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgHoldoff, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd24, 16'd65535, 1'b1, OutcomeNone, 8'd1},
    '{1'b0, CfgLowThr, 32'd0, 47'd25, 16'd65534, 1'b1, OutcomeReport, 8'd2},
    '{1'b0, CfgLowThr, 32'd0, 47'd26, 16'd65534, 1'b1, OutcomeNone, 8'd1},
    '{1'b1, CfgInterval, 32'd100, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd100, 16'd0, 1'b1, OutcomeSkip, 8'd1},
    '{1'b0, CfgLowThr, 32'd0, 47'd126, 16'd0, 1'b1, OutcomeReport, 8'd2},
    '{1'b0, CfgLowThr, 32'd0, 47'd5, 16'd0, 1'b1, OutcomeSkip, 8'd2},
    '{1'b1, CfgInterval, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd5, 16'd0, 1'b1, OutcomeSkip, 8'd2},
    '{1'b0, CfgLowThr, 32'd0, 47'd126, 16'd0, 1'b1, OutcomeNone, 8'd0},
    '{1'b1, CfgHoldoff, 32'hFFFF_FFFF, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgLevel, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'd127, 16'd7, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'h1_0000_007D, 16'd0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgLevel, 32'd255, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgHoldoff, 32'd0, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'h1_0000_007E, 16'd0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b1, CfgLevel, 32'd1, '0, '0, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'h1_0000_007F, 16'd65535, 1'b0, OutcomeSkip, 8'd0},
    '{1'b0, CfgLowThr, 32'd0, 47'h1_0000_0080, 16'd0, 1'b0, OutcomeSkip, 8'd0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // now_time[46:0], change_count[62:47], zero pad
  logic [63:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // outcome[1:0], tracking_level[9:2], zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  motion_report_decider_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // decider shadow: thresholds, timing and tracking state
  logic [ThrW-1:0]   low_q;
  logic [ThrW-1:0]   high_q;
  logic [IntvW-1:0]  interval_q;
  logic [IntvW-1:0]  holdoff_q;
  logic [LevelW-1:0] level_q;
  logic [TimeW-1:0]  last_frame_t;
  logic [TimeW-1:0]  last_report_t;
  logic              frame_seen;
  logic              report_seen;
  logic [LevelW-1:0] track;
  logic              reported_prev;

  res_t decision_q[$];
  int   bad_count;
  int   results_seen;
  int   quiet_cycles;
  bit   calm;
  bit   held_long;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic res_t decide_frame(input logic [TimeW-1:0] now,
                                        input logic [CountW-1:0] cnt);
    logic [63:0] now64;
    logic [63:0] fref;
    logic [63:0] rref;
    res_t d;
    now64 = {17'b0, now};
    fref = frame_seen ? {17'b0, last_frame_t} : {32'b0, interval_q};
    if (now64 < fref + {32'b0, interval_q}) begin
      d.outcome = OutcomeSkip;
      d.level = track;
      return d;
    end
    last_frame_t = now;
    frame_seen = 1'b1;
    if (track >= level_q && reported_prev) track = '0;
    if (track == 0 && cnt > high_q) begin
      track = 8'd1;
    end else if (track == 1 && cnt < low_q) begin
      track = QuietStart;
    end else if (track >= QuietStart) begin
      if (cnt < low_q) begin
        if (track != CounterMax) track = track + 8'd1;
      end else begin
        track = 8'd1;
      end
    end
    rref = report_seen ? {17'b0, last_report_t} : {32'b0, holdoff_q};
    if (track >= level_q && now64 >= rref + {32'b0, holdoff_q}) begin
      last_report_t = now;
      report_seen = 1'b1;
      reported_prev = 1'b1;
      d.outcome = OutcomeReport;
    end else begin
      reported_prev = 1'b0;
      d.outcome = OutcomeNone;
    end
    d.level = track;
    return d;
  endfunction

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgLowThr:   low_q = val[ThrW-1:0];
      CfgHighThr:  high_q = val[ThrW-1:0];
      CfgInterval: interval_q = val;
      CfgHoldoff:  holdoff_q = val;
      CfgLevel:    level_q = val[LevelW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic offer_frame(input logic [TimeW-1:0] now, input logic [CountW-1:0] cnt,
                             input logic typed, input res_t fixed);
    int   gap;
    res_t want;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, cnt, now};
    do @(posedge clk_i); while (!s_axis_tready);
    want = decide_frame(now, cnt);
    decision_q.push_back(typed ? fixed : want);
    @(negedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off to back up the pipe
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_long && results_seen >= 120) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (decision_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected item: outcome %0d level %0d",
                     m_axis_tdata[1:0], m_axis_tdata[9:2]);
        end else begin
          want = decision_q.pop_front();
          if (m_axis_tdata[1:0] !== want.outcome || m_axis_tdata[9:2] !== want.level ||
              m_axis_tdata[15:10] !== '0) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"item %0d: expected outcome %0d level %0d, ",
                        "got outcome %0d level %0d pad %h"},
                       results_seen, want.outcome, want.level,
                       m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[15:10]);
          end
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0]       cursor;
    logic [63:0]       step;
    logic [63:0]       base;
    logic [ThrW-1:0]   lo;
    logic [ThrW-1:0]   hi;
    logic [IntvW-1:0]  iv;
    logic [IntvW-1:0]  ho;
    logic [LevelW-1:0] lv;
    logic [CountW-1:0] cnt;
    logic [TimeW-1:0]  now;
    bit                long_run;
    int                n;
    int                r;
    res_t              fixed;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    low_q = '0;
    high_q = '0;
    interval_q = '0;
    holdoff_q = '0;
    level_q = LevelReset;
    last_frame_t = '0;
    last_report_t = '0;
    frame_seen = 1'b0;
    report_seen = 1'b0;
    track = '0;
    reported_prev = 1'b0;
    bad_count = 0;
    results_seen = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    held_long = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 33; i++) begin
      if (Plan[i].is_cfg) begin
        if (i == 0 || !Plan[i-1].is_cfg) settle();
        set_reg(Plan[i].idx, Plan[i].wdata);
      end else begin
        if (Plan[i-1].is_cfg) cfg_we_i <= 1'b0;
        fixed.outcome = Plan[i].oc;
        fixed.level = Plan[i].lv;
        offer_frame(Plan[i].now, Plan[i].cnt, Plan[i].typed, fixed);
      end
    end

    cursor = 64'h1_0000_0080;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin
          lo = 16'd100; hi = 16'd200; iv = '0; ho = '0; lv = 8'd2;
        end
        1: begin
          lo = '0; hi = '0; iv = $urandom_range(1, 50); ho = $urandom_range(0, 200);
          lv = 8'd1;
        end
        2: begin
          // saturate the quiet count and let it report at the top
          lo = 16'hFFFF; hi = '0; iv = '0; ho = '0; lv = CounterMax;
        end
        3: begin
          lo = 16'hFFFF; hi = 16'hFFFF; iv = 32'hFFFF_FFFF; ho = 32'hFFFF_FFFF; lv = '0;
        end
        4: begin
          lo = 16'($urandom_range(0, 40000)); hi = 16'($urandom_range(lo, 65535));
          iv = $urandom_range(0, 1000); ho = $urandom_range(0, 5000);
          lv = 8'($urandom_range(2, 6));
        end
        5: begin
          lo = 16'($urandom); hi = 16'($urandom); iv = $urandom; ho = $urandom; lv = '0;
        end
        6: begin
          lo = 16'($urandom_range(0, 40000)); hi = 16'($urandom_range(lo, 65535));
          iv = $urandom_range(0, 20); ho = $urandom_range(0, 100); lv = 8'd3;
        end
        default: begin
          lo = 16'($urandom_range(0, 40000)); hi = 16'($urandom_range(lo, 65535));
          iv = $urandom_range(0, 20); ho = $urandom_range(0, 100);
          lv = 8'($urandom_range(1, 8));
        end
      endcase
      settle();
      set_reg(CfgLowThr, {16'b0, lo});
      set_reg(CfgHighThr, {16'b0, hi});
      set_reg(CfgInterval, iv);
      set_reg(CfgHoldoff, ho);
      set_reg(CfgLevel, {24'b0, lv});
      cfg_we_i <= 1'b0;

      long_run = (k == 2);
      calm = (k == 7);
      n = long_run ? 270 : 25;
      base = {$urandom, $urandom};
      base = (64'(k) << 44) | (base & 64'h0FFF_FFFF_FFFF);
      if (base > cursor) cursor = base;

      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 7);
        if (long_run) begin
          cnt = 16'($urandom_range(1, 65534));
        end else if (r < 2) begin
          cnt = (hi != 16'hFFFF) ? 16'($urandom_range(hi + 1, 65535)) : 16'hFFFF;
        end else if (r < 6) begin
          cnt = (lo != 0) ? 16'($urandom_range(0, lo - 1)) : 16'd0;
        end else if (r == 6) begin
          cnt = 16'($urandom);
        end else begin
          cnt = $urandom_range(0, 1) ? lo : hi;
        end

        r = $urandom_range(0, 9);
        if (k == 7 && i == n - 1) begin
          now = TimeMax[TimeW-1:0];
        end else if (r == 1 && !long_run && cursor > 16) begin
          // a frame stamped in the past
          now = TimeW'(cursor - 64'($urandom_range(1, 16)));
        end else begin
          if (r == 0)
            step = '0;
          else if (r == 2)
            step = 64'($urandom_range(0, iv));
          else
            step = {32'b0, iv} + (($urandom_range(0, 3) == 0) ?
                   {32'b0, ho} : 64'($urandom_range(0, 20)));
          cursor = (cursor + step > TimeMax) ? TimeMax : cursor + step;
          now = cursor[TimeW-1:0];
        end
        offer_frame(now, cnt, 1'b0, '0);
      end
    end

    settle();
    if (bad_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mrd_pkg.sv
rtl/core/mrd_cfg_regs.sv
rtl/core/mrd_in_reg.sv
rtl/core/mrd_decide.sv
rtl/core/mrd_out_reg.sv
rtl/core/motion_report_decider_core.sv
bench/motion_report_decider_core_tb.sv
